// ===== rtl/core/fixed_point_decimal_formatter_macros.svh =====
// assertion helpers for the fixed-point decimal formatter
// every macro samples on clk_i and is disabled while rst_ni is low
`ifndef FIXED_POINT_DECIMAL_FORMATTER_MACROS_SVH
`define FIXED_POINT_DECIMAL_FORMATTER_MACROS_SVH

// same-cycle implication
`define FPDF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpdf assertion failed");

// implication checked in the next cycle
`define FPDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpdf assertion failed");

`endif

// ===== rtl/core/fpdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_pkg
// shared types and constants of the fixed-point decimal formatter
// ----------------------------------------------------------------------------
package fpdf_pkg;

  typedef enum logic [1:0] {
    FMT_HUND_U = 2'd0,
    FMT_HUND_S = 2'd1,
    FMT_THOU_S = 2'd2,
    FMT_BIN256 = 2'd3
  } format_e;

  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_WIDE   = 1'b1
  } reg_idx_e;

  // binary number converted to five decimal digits (at most 99999)
  typedef logic [16:0] num_t;

  typedef struct packed {
    format_e fmt;
    logic    neg;
    logic    err;
  } ctl_t;

  typedef struct packed {
    logic [3:0] d4;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } digits_t;

  localparam logic [31:0] HUND_MAX = 32'd99999;
  localparam logic [31:0] THOU_MAX = 32'd9999;
  localparam logic [31:0] BIN_MAX  = 32'd255999;

  // exact reciprocals for values below 100000
  localparam logic [32:0] RECIP10   = 33'd52429;  // >> 19
  localparam logic [33:0] RECIP1000 = 34'd67109;  // >> 26

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

// ===== rtl/core/fpdf_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_prep
// two stages: magnitude, range check and mode select, then rescale or packing
// ----------------------------------------------------------------------------
module fpdf_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         value_i,
  input  fpdf_pkg::format_e   fmt_i,
  input  logic                wide_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fpdf_pkg::num_t      num_o,
  output fpdf_pkg::ctl_t      ctl_o
);

  logic           a_valid_q, b_valid_q;
  logic           a_ready, b_ready;
  fpdf_pkg::num_t a_num_q, a_num_d, b_num_q, b_num_d;
  fpdf_pkg::ctl_t a_ctl_q, a_ctl_d, b_ctl_q;
  logic           a_resc_q, a_resc_d;

  logic [31:0] mag;
  logic [7:0]  r_clamp;
  logic [12:0] fr_prod;
  logic [32:0] resc_prod;
  logic [16:0] ip_val;

  assign a_ready = !a_valid_q || b_ready;
  assign b_ready = !b_valid_q || out_ready_i;

  // stage a
  always_comb begin
    mag      = value_i[31] ? (32'd0 - value_i) : value_i;
    r_clamp  = (value_i[7:0] == 8'hFF) ? 8'hFE : value_i[7:0];
    fr_prod  = 13'(r_clamp) * 13'd25;
    a_num_d  = mag[16:0];
    a_resc_d = 1'b0;
    a_ctl_d.fmt = fmt_i;
    a_ctl_d.neg = value_i[31];
    a_ctl_d.err = 1'b0;
    case (fmt_i)
      fpdf_pkg::FMT_HUND_U: begin
        a_num_d     = value_i[16:0];
        a_ctl_d.err = value_i > fpdf_pkg::HUND_MAX;
      end
      fpdf_pkg::FMT_HUND_S: begin
        a_ctl_d.err = mag > fpdf_pkg::HUND_MAX;
      end
      fpdf_pkg::FMT_THOU_S: begin
        if (mag > fpdf_pkg::THOU_MAX) begin
          // rescaled value fits iff the magnitude is at most 99999
          a_resc_d    = 1'b1;
          a_ctl_d.err = !wide_i || (mag > fpdf_pkg::HUND_MAX);
        end
      end
      default: begin
        // integer part above the fraction, joined later as ip*100 + fr
        a_num_d     = {value_i[17:8], fr_prod[12:6]};
        a_ctl_d.err = value_i > fpdf_pkg::BIN_MAX;
      end
    endcase
  end

  // stage b
  always_comb begin
    resc_prod = 33'(a_num_q) * fpdf_pkg::RECIP10;
    ip_val    = 17'(a_num_q[16:7]) * 17'd100 + 17'(a_num_q[6:0]);
    if (a_ctl_q.fmt == fpdf_pkg::FMT_BIN256) begin
      b_num_d = ip_val;
    end else if (a_resc_q) begin
      b_num_d = 17'(resc_prod[32:19]);
    end else begin
      b_num_d = a_num_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_num_q  <= a_num_d;
      a_ctl_q  <= a_ctl_d;
      a_resc_q <= a_resc_d;
    end
    if (b_ready && a_valid_q) begin
      b_num_q <= b_num_d;
      b_ctl_q <= a_ctl_q;
    end
  end

  assign in_ready_o  = a_ready;
  assign out_valid_o = b_valid_q;
  assign num_o       = b_num_q;
  assign ctl_o       = b_ctl_q;

endmodule

// ===== rtl/core/fpdf_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_split
// three stages that take a number below 100000 apart into five decimal digits
// ----------------------------------------------------------------------------
module fpdf_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fpdf_pkg::num_t      num_i,
  input  fpdf_pkg::ctl_t      ctl_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fpdf_pkg::digits_t   dig_o,
  output fpdf_pkg::ctl_t      ctl_o
);

  logic c_valid_q, d_valid_q, e_valid_q;
  logic c_ready, d_ready, e_ready;

  fpdf_pkg::num_t    c_num_q;
  logic [6:0]        c_quo_q;
  fpdf_pkg::ctl_t    c_ctl_q, d_ctl_q, e_ctl_q;
  logic [9:0]        d_lo3_q;
  logic [3:0]        d_d4_q, d_d3_q;
  fpdf_pkg::digits_t e_dig_q, e_dig_d;

  logic [33:0] quo_prod;
  logic [16:0] lo3_full;
  logic [14:0] d4_prod;
  logic [6:0]  d3_full;
  logic [3:0]  d4_val;
  logic [15:0] h_prod;
  logic [9:0]  lo2_full;
  logic [14:0] t_prod;
  logic [6:0]  o_full;

  assign c_ready = !c_valid_q || d_ready;
  assign d_ready = !d_valid_q || e_ready;
  assign e_ready = !e_valid_q || out_ready_i;

  // stage c: thousands quotient
  assign quo_prod = 34'(num_i) * fpdf_pkg::RECIP1000;

  // stage d: low three digits, top two digits
  always_comb begin
    lo3_full = c_num_q - 17'(c_quo_q) * 17'd1000;
    d4_prod  = 15'(c_quo_q) * 15'd205;
    d4_val   = d4_prod[14:11];
    d3_full  = c_quo_q - 7'(d4_val) * 7'd10;
  end

  // stage e: hundreds, tens, ones
  always_comb begin
    h_prod     = 16'(d_lo3_q) * 16'd41;
    lo2_full   = d_lo3_q - 10'(h_prod[15:12]) * 10'd100;
    t_prod     = 15'(lo2_full[6:0]) * 15'd205;
    o_full     = lo2_full[6:0] - 7'(t_prod[14:11]) * 7'd10;
    e_dig_d.d4 = d_d4_q;
    e_dig_d.d3 = d_d3_q;
    e_dig_d.d2 = h_prod[15:12];
    e_dig_d.d1 = t_prod[14:11];
    e_dig_d.d0 = o_full[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= in_valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
      if (e_ready) begin
        e_valid_q <= d_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_num_q <= num_i;
      c_quo_q <= quo_prod[32:26];
      c_ctl_q <= ctl_i;
    end
    if (d_ready && c_valid_q) begin
      d_lo3_q <= lo3_full[9:0];
      d_d4_q  <= d4_val;
      d_d3_q  <= d3_full[3:0];
      d_ctl_q <= c_ctl_q;
    end
    if (e_ready && d_valid_q) begin
      e_dig_q <= e_dig_d;
      e_ctl_q <= d_ctl_q;
    end
  end

  assign in_ready_o  = c_ready;
  assign out_valid_o = e_valid_q;
  assign dig_o       = e_dig_q;
  assign ctl_o       = e_ctl_q;

endmodule

// ===== rtl/core/fpdf_glyph.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_glyph
// output register: digits, blanking, sign and star patterns into ascii
// ----------------------------------------------------------------------------
module fpdf_glyph (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fpdf_pkg::digits_t   dig_i,
  input  fpdf_pkg::ctl_t      ctl_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [55:0]         chars_o,
  output logic                oor_o
);

  logic            o_valid_q;
  logic            o_ready;
  logic [6:0][7:0] ch_d, ch_q;
  logic            oor_q;
  logic [5:0][7:0] txt;
  logic [5:0][7:0] stars;

  function automatic logic [7:0] ascii_digit(input logic [3:0] d);
    ascii_digit = fpdf_pkg::CH_ZERO | {4'h0, d};
  endfunction

  assign o_ready = !o_valid_q || out_ready_i;

  always_comb begin
    // hundredths text with leading-zero blanking of hundreds and tens
    txt[0] = (dig_i.d4 == 4'd0) ? fpdf_pkg::CH_BLANK : ascii_digit(dig_i.d4);
    txt[1] = (dig_i.d4 == 4'd0 && dig_i.d3 == 4'd0) ? fpdf_pkg::CH_BLANK
                                                     : ascii_digit(dig_i.d3);
    txt[2] = ascii_digit(dig_i.d2);
    txt[3] = fpdf_pkg::CH_DOT;
    txt[4] = ascii_digit(dig_i.d1);
    txt[5] = ascii_digit(dig_i.d0);
    stars  = {fpdf_pkg::CH_STAR, fpdf_pkg::CH_STAR, fpdf_pkg::CH_DOT,
              fpdf_pkg::CH_STAR, fpdf_pkg::CH_STAR, fpdf_pkg::CH_STAR};
    ch_d   = '0;
    case (ctl_i.fmt) inside
      fpdf_pkg::FMT_HUND_S: begin
        ch_d[0]   = fpdf_pkg::CH_BLANK;
        ch_d[6:1] = ctl_i.err ? stars : txt;
        if (ctl_i.neg) begin
          // minus goes on the blank just left of the first printed char
          if (ctl_i.err || dig_i.d4 != 4'd0) begin
            ch_d[0] = fpdf_pkg::CH_MINUS;
          end else if (dig_i.d3 != 4'd0) begin
            ch_d[1] = fpdf_pkg::CH_MINUS;
          end else begin
            ch_d[2] = fpdf_pkg::CH_MINUS;
          end
        end
      end
      fpdf_pkg::FMT_THOU_S: begin
        if (ctl_i.err) begin
          ch_d[0] = fpdf_pkg::CH_BLANK;
          ch_d[1] = fpdf_pkg::CH_STAR;
          ch_d[2] = fpdf_pkg::CH_DOT;
          ch_d[3] = fpdf_pkg::CH_STAR;
          ch_d[4] = fpdf_pkg::CH_STAR;
          ch_d[5] = fpdf_pkg::CH_STAR;
        end else begin
          ch_d[0] = ctl_i.neg ? fpdf_pkg::CH_MINUS : fpdf_pkg::CH_BLANK;
          ch_d[1] = ascii_digit(dig_i.d3);
          ch_d[2] = fpdf_pkg::CH_DOT;
          ch_d[3] = ascii_digit(dig_i.d2);
          ch_d[4] = ascii_digit(dig_i.d1);
          ch_d[5] = ascii_digit(dig_i.d0);
        end
        ch_d[6] = fpdf_pkg::CH_NUL;
      end
      fpdf_pkg::FMT_HUND_U, fpdf_pkg::FMT_BIN256: begin
        ch_d[5:0] = ctl_i.err ? stars : txt;
        ch_d[6]   = fpdf_pkg::CH_NUL;
      end
      default: begin
        ch_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && in_valid_i) begin
      ch_q  <= ch_d;
      oor_q <= ctl_i.err;
    end
  end

  assign in_ready_o  = o_ready;
  assign out_valid_o = o_valid_q;
  assign chars_o     = ch_q;
  assign oor_o       = oor_q;

endmodule

// ===== rtl/core/fixed_point_decimal_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter
// 32-bit fixed-point value to seven ascii display characters
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one 32-bit value per beat; m_axis returns one beat per
//   input with seven characters in tdata and the out-of-range flag in tuser
//   the cfg port selects the format (unsigned or signed hundredths, signed
//   thousandths, unsigned 1/256) and the thousandths rescale; write it only
//   while no beat is in flight
//   six register stages: magnitude and range check, rescale or packing,
//   thousands quotient, upper digits, lower digits, output register
//   while m_axis_tready_i is high, throughput is one beat per cycle; each
//   stage holds one beat and moves on when the stage after it is empty or
//   moving, so bubbles are squeezed out
//   when m_axis_tready_i is low the output holds and the stages behind it
//   fill up; s_axis_tready_o drops only when all six stages are full
//   reset clears all valid bits and loads format 0 with rescale on; data
//   registers keep whatever they hold
// ----------------------------------------------------------------------------
`include "fixed_point_decimal_formatter_macros.svh"

module fixed_point_decimal_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // char0, char1, ..., char6
  output logic [0:0]  m_axis_tuser_o    // out_of_range
);

  // configuration registers
  fpdf_pkg::format_e fmt_q;
  logic              wide_q;

  // prep -> split
  logic              prep_valid, split_ready;
  fpdf_pkg::num_t    prep_num;
  fpdf_pkg::ctl_t    prep_ctl;

  // split -> glyph
  logic              split_valid, glyph_ready;
  fpdf_pkg::digits_t split_dig;
  fpdf_pkg::ctl_t    split_ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= fpdf_pkg::FMT_HUND_U;
      wide_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (fpdf_pkg::reg_idx_e'(cfg_idx_i))
        fpdf_pkg::REG_FORMAT: fmt_q  <= fpdf_pkg::format_e'(cfg_wdata_i);
        fpdf_pkg::REG_WIDE:   wide_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // sign, range and mode select, then rescale by ten or 1/256 packing
  fpdf_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .value_i     (s_axis_tdata_i),
    .fmt_i       (fmt_q),
    .wide_i      (wide_q),
    .out_valid_o (prep_valid),
    .out_ready_i (split_ready),
    .num_o       (prep_num),
    .ctl_o       (prep_ctl)
  );

  // five decimal digits by constant reciprocals
  fpdf_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (split_ready),
    .num_i       (prep_num),
    .ctl_i       (prep_ctl),
    .out_valid_o (split_valid),
    .out_ready_i (glyph_ready),
    .dig_o       (split_dig),
    .ctl_o       (split_ctl)
  );

  // ascii text into the output register
  fpdf_glyph u_glyph (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (split_valid),
    .in_ready_o  (glyph_ready),
    .dig_i       (split_dig),
    .ctl_i       (split_ctl),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .chars_o     (m_axis_tdata_o),
    .oor_o       (m_axis_tuser_o[0])
  );

  // an empty output stage means every stage can take a beat
  `FPDF_ASSERT_IMPLIES(a_ready_when_drained, !m_axis_tvalid_o, s_axis_tready_o)

  // an in-range result always holds a decimal digit in char5
  `FPDF_ASSERT_IMPLIES(a_char5_digit, m_axis_tvalid_o && !m_axis_tuser_o[0],
    (m_axis_tdata_o[47:44] == 4'h3) && (m_axis_tdata_o[43:40] <= 4'd9))

  // every pattern carries its point in char2, char3 or char4
  `FPDF_ASSERT_IMPLIES(a_point_place, m_axis_tvalid_o,
    (m_axis_tdata_o[23:16] == fpdf_pkg::CH_DOT) ||
    (m_axis_tdata_o[31:24] == fpdf_pkg::CH_DOT) ||
    (m_axis_tdata_o[39:32] == fpdf_pkg::CH_DOT))

endmodule
